// ===== hw/rtl/odct_pkg.sv =====
// shared widths and sizes for the orthonormal dct block engine
`default_nettype none

package odct_pkg;

  localparam int MAX_SIZE  = 64;
  localparam int SIZE_W    = 7;
  localparam int IDX_W     = 6;
  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 19;
  localparam int COS_W     = 29;
  localparam int WGT_W     = 28;
  // first-quadrant cosine entries of every block size, m = 0..N for each N
  localparam int ROM_DEPTH = MAX_SIZE * (MAX_SIZE + 3) / 2;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

endpackage

`default_nettype wire

// ===== hw/rtl/odct_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module odct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/odct_cos_rom.sv =====
// cosine and weight tables for every block size, built at elaboration
`default_nettype none

module odct_cos_rom (
  input  wire logic                          clk,
  input  wire logic [odct_pkg::SIZE_W-1:0]   size,
  input  wire logic [odct_pkg::SIZE_W-1:0]   m,
  output logic      [odct_pkg::COS_W-1:0]    cos_mag,
  output logic      [odct_pkg::WGT_W-1:0]    w0,
  output logic      [odct_pkg::WGT_W-1:0]    w1
);

  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
  localparam int COS_W_L = odct_pkg::COS_W;
  localparam int WGT_W_L = odct_pkg::WGT_W;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] pr;
    begin
      pr = {64'd0, a} * {64'd0, b};
      return pr[125:62];
    end
  endfunction

  // taylor term divisors (2i-1)(2i) for cosine, (2i)(2i+1) for sine
  function automatic logic [63:0] div_term(input logic [63:0] v, input int i,
                                           input logic use_sin);
    logic [63:0] r;
    begin
      case (i)
        1:       r = use_sin ? v / 64'd6   : v / 64'd2;
        2:       r = use_sin ? v / 64'd20  : v / 64'd12;
        3:       r = use_sin ? v / 64'd42  : v / 64'd30;
        4:       r = use_sin ? v / 64'd72  : v / 64'd56;
        5:       r = use_sin ? v / 64'd110 : v / 64'd90;
        6:       r = use_sin ? v / 64'd156 : v / 64'd132;
        7:       r = use_sin ? v / 64'd210 : v / 64'd182;
        8:       r = use_sin ? v / 64'd272 : v / 64'd240;
        9:       r = use_sin ? v / 64'd342 : v / 64'd306;
        10:      r = use_sin ? v / 64'd420 : v / 64'd380;
        11:      r = use_sin ? v / 64'd506 : v / 64'd462;
        12:      r = use_sin ? v / 64'd600 : v / 64'd552;
        default: r = 64'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [COS_W_L-1:0] cos_series(input logic [63:0] x,
                                                    input logic use_sin);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] q;
    begin
      x2 = mul_q62(x, x);
      if (use_sin) begin
        sum = x;
        t   = x;
      end else begin
        sum = 64'd1 << 62;
        t   = 64'd1 << 62;
      end
      for (int i = 1; i <= 12; i++) begin
        t = div_term(mul_q62(t, x2), i, use_sin);
        if ((i % 2) == 1) sum = sum - t;
        else sum = sum + t;
      end
      q = (sum + (64'd1 << 33)) >> 34;
      return q[COS_W_L-1:0];
    end
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    begin
      v   = val;
      res = 64'd0;
      b   = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
        if (b > v) b = b >> 2;
      end
      for (int k = 0; k < 32; k++) begin
        if (b != 64'd0) begin
          if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
          end else begin
            res = res >> 1;
          end
          b = b >> 2;
        end
      end
      return res;
    end
  endfunction

  function automatic logic [WGT_W_L-1:0] weight(input logic [63:0] s);
    logic [63:0] twice;
    logic [63:0] w;
    begin
      twice = isqrt64(s);
      w     = (twice + 64'd1) >> 1;
      return w[WGT_W_L-1:0];
    end
  endfunction

  logic [odct_pkg::COS_W-1:0]  cos_tab  [odct_pkg::ROM_DEPTH];
  logic [odct_pkg::ROM_AW-1:0] base_tab [odct_pkg::MAX_SIZE];
  logic [odct_pkg::WGT_W-1:0]  w0_tab   [odct_pkg::MAX_SIZE];
  logic [odct_pkg::WGT_W-1:0]  w1_tab   [odct_pkg::MAX_SIZE];

  for (genvar GN = 1; GN <= odct_pkg::MAX_SIZE; GN++) begin : g_size
    localparam logic [63:0] QUO  = PI_HALF_Q62 / GN;
    localparam logic [63:0] REM  = PI_HALF_Q62 % GN;
    localparam int          BASE = (GN - 1) * (GN + 2) / 2;
    localparam logic [63:0] S0   = (64'd1 << 56) / GN;
    localparam logic [63:0] S1   = (64'd2 << 56) / GN;

    for (genvar GM = 0; GM <= GN; GM++) begin : g_entry
      localparam logic        USE_SIN = (2 * GM > GN);
      localparam logic [63:0] MA      = USE_SIN ? 64'(GN - GM) : 64'(GM);
      localparam logic [63:0] XANG    = QUO * MA + (REM * MA) / GN;
      assign cos_tab[BASE + GM] = cos_series(XANG, USE_SIN);
    end

    assign base_tab[GN - 1] = odct_pkg::ROM_AW'(BASE);
    assign w0_tab[GN - 1]   = weight(S0);
    assign w1_tab[GN - 1]   = weight(S1);
  end

  logic [odct_pkg::IDX_W-1:0]  size_idx;
  logic [odct_pkg::ROM_AW-1:0] addr;

  assign size_idx = odct_pkg::IDX_W'(size - odct_pkg::SIZE_W'(1));
  assign addr     = base_tab[size_idx] + odct_pkg::ROM_AW'(m);
  assign w0       = w0_tab[size_idx];
  assign w1       = w1_tab[size_idx];

  always_ff @(posedge clk) begin
    cos_mag <= cos_tab[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/orthonormal_dct_block_engine.sv =====
// Orthonormal DCT-II / DCT-III engine over blocks of 1 to 64 Q1.15 samples.
// Samples are taken while the engine is collecting; the sample that fills the
// block starts the transform and in_ready stays low until the last result has
// been placed in the output register. Each result runs one shared 20x30
// multiplier: N multiply-accumulate steps through a four-stage pipeline
// (sample ram and cosine rom reads, product, accumulate), then four partial
// products for the weighting. The shared multiplier is what sets the time
// that a block takes. Block size and direction are taken when a block fills.
`default_nettype none

module orthonormal_dct_block_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [15:0]   sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [18:0]        value,
  output logic                      last
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_SETUP   = 3'd1;
  localparam logic [2:0] ST_MAC     = 3'd2;
  localparam logic [2:0] ST_DRAIN   = 3'd3;
  localparam logic [2:0] ST_WMUL    = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_DIR  = 1'b1;

  localparam int SW = odct_pkg::SIZE_W;
  localparam int IW = odct_pkg::IDX_W;

  logic [2:0]    state;
  logic [SW-1:0] block_size;
  logic          direction;
  logic [IW-1:0] fill;
  logic [SW-1:0] n_reg;
  logic          dir_blk;
  logic [IW-1:0] i_reg;
  logic [IW-1:0] j_reg;
  logic [7:0]    idx;
  logic [7:0]    step;

  logic          s1_v, s1_first, s1_neg;
  logic [IW-1:0] s1_j;
  logic [SW-1:0] s1_m;
  logic          s2_v, s2_first, s2_neg;
  logic          s3_v, s3_first;

  logic signed [49:0] prod;
  logic signed [50:0] acc;
  logic signed [50:0] a0;
  logic signed [36:0] r0;
  logic signed [36:0] r1;
  logic [odct_pkg::WGT_W-1:0] wk;
  logic [2:0]         wcnt;
  logic signed [67:0] p;

  logic [odct_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [odct_pkg::COS_W-1:0]    cos_mag;
  logic [odct_pkg::WGT_W-1:0]    w0;
  logic [odct_pkg::WGT_W-1:0]    w1;

  logic          in_acc;
  logic          cfg_wr;
  logic [SW-1:0] nsz;
  logic [SW-1:0] fill_inc;
  logic [8:0]    four_n;
  logic [8:0]    two_n;
  logic [8:0]    idx_sum;
  logic [8:0]    mf;
  logic [8:0]    mq;
  logic          fold_neg;
  logic          pipe_empty;
  logic          last_i;
  logic          load_out;

  logic signed [19:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [29:0] cos_s;
  logic signed [50:0] acc_rnd;
  logic signed [50:0] a0_rnd;
  logic signed [67:0] psext;
  logic signed [67:0] pterm;
  logic signed [67:0] p_rnd;
  logic signed [26:0] rv;
  logic signed [18:0] sat_v;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_SIZE: prdata = {25'd0, block_size};
      REG_DIR:  prdata = {31'd0, direction};
      default:  prdata = 32'd0;
    endcase
  end

  assign in_ready = (state == ST_COLLECT);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    if (block_size == SW'(0)) nsz = SW'(1);
    else if (block_size > SW'(odct_pkg::MAX_SIZE)) nsz = SW'(odct_pkg::MAX_SIZE);
    else nsz = block_size;
  end
  assign fill_inc = SW'(fill) + SW'(1);

  // cosine index folding into the first quadrant
  assign four_n  = {n_reg, 2'b00};
  assign two_n   = {1'b0, n_reg, 1'b0};
  assign idx_sum = {1'b0, idx} + {1'b0, step};

  always_comb begin
    if ({1'b0, idx} > two_n) mf = four_n - {1'b0, idx};
    else mf = {1'b0, idx};
    fold_neg = (mf > {2'b00, n_reg});
    if (fold_neg) mq = two_n - mf;
    else mq = mf;
  end

  odct_ram #(
    .WIDTH(odct_pkg::SAMPLE_W),
    .DEPTH(odct_pkg::MAX_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (in_acc),
    .waddr(fill),
    .wdata(sample),
    .raddr(s1_j),
    .rdata(ram_rdata)
  );

  odct_cos_rom u_rom (
    .clk    (clk),
    .size   (n_reg),
    .m      (s1_m),
    .cos_mag(cos_mag),
    .w0     (w0),
    .w1     (w1)
  );

  // shared multiplier operand select
  assign cos_s = $signed({1'b0, cos_mag});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_WMUL) begin
      case (wcnt)
        3'd0: begin
          mul_a = $signed({2'b00, r0[17:0]});
          mul_b = $signed({2'b00, w0});
        end
        3'd1: begin
          mul_a = {r0[36], r0[36:18]};
          mul_b = $signed({2'b00, w0});
        end
        3'd2: begin
          mul_a = $signed({2'b00, r1[17:0]});
          mul_b = $signed({2'b00, wk});
        end
        3'd3: begin
          mul_a = {r1[36], r1[36:18]};
          mul_b = $signed({2'b00, wk});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else begin
      mul_a = {{4{ram_rdata[15]}}, ram_rdata};
      mul_b = s2_neg ? -cos_s : cos_s;
    end
  end

  assign pipe_empty = !s1_v && !s2_v && !s3_v;
  assign acc_rnd    = acc + 51'sd8192;
  assign a0_rnd     = a0 + 51'sd8192;
  assign psext      = {{18{prod[49]}}, prod};
  // odd partial products carry the upper half of the rounded sum
  assign pterm      = (wcnt == 3'd2 || wcnt == 3'd4) ? (psext <<< 18) : psext;
  assign p_rnd      = p + (68'sd1 <<< 40);
  assign rv         = p_rnd[67:41];

  always_comb begin
    if (rv > 27'sd262143) sat_v = 19'sh3FFFF;
    else if (rv < -27'sd262144) sat_v = 19'sh40000;
    else sat_v = rv[18:0];
  end

  assign last_i   = ({1'b0, i_reg} == n_reg - SW'(1));
  assign load_out = (state == ST_EMIT) && (!out_valid || out_ready);

  // payload and pipeline data
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    s1_first <= dir_blk && (j_reg == IW'(0));
    s1_neg   <= fold_neg;
    s1_m     <= mq[SW-1:0];
    s1_j     <= j_reg;
    s2_first <= s1_first;
    s2_neg   <= s1_neg;
    s3_first <= s2_first;
    if (state == ST_SETUP) begin
      acc <= '0;
      a0  <= '0;
    end else if (s3_v) begin
      if (s3_first) a0 <= a0 + {prod[49], prod};
      else acc <= acc + {prod[49], prod};
    end
    if (state == ST_DRAIN && pipe_empty) begin
      r0 <= a0_rnd[50:14];
      r1 <= acc_rnd[50:14];
      wk <= (dir_blk || i_reg != IW'(0)) ? w1 : w0;
      p  <= '0;
    end else if (state == ST_WMUL && wcnt != 3'd0) begin
      p <= p + pterm;
    end
    if (load_out) begin
      value <= sat_v;
      last  <= last_i;
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      block_size <= SW'(8);
      direction  <= 1'b0;
      fill       <= '0;
      n_reg      <= SW'(8);
      dir_blk    <= 1'b0;
      i_reg      <= '0;
      j_reg      <= '0;
      idx        <= '0;
      step       <= '0;
      wcnt       <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      s3_v       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_SIZE: block_size <= pwdata[SW-1:0];
          REG_DIR:  direction  <= pwdata[0];
          default:  ;
        endcase
      end

      s1_v <= (state == ST_MAC);
      s2_v <= s1_v;
      s3_v <= s2_v;

      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_COLLECT: begin
          if (in_acc) begin
            if (fill_inc >= nsz) begin
              fill    <= '0;
              n_reg   <= nsz;
              dir_blk <= direction;
              i_reg   <= '0;
              state   <= ST_SETUP;
            end else begin
              fill <= fill_inc[IW-1:0];
            end
          end
        end
        ST_SETUP: begin
          j_reg <= '0;
          idx   <= dir_blk ? 8'd0 : {2'b00, i_reg};
          step  <= dir_blk ? {1'b0, i_reg, 1'b1} : {1'b0, i_reg, 1'b0};
          state <= ST_MAC;
        end
        ST_MAC: begin
          idx <= (idx_sum >= four_n) ? 8'(idx_sum - four_n) : idx_sum[7:0];
          if ({1'b0, j_reg} == n_reg - SW'(1)) begin
            state <= ST_DRAIN;
          end else begin
            j_reg <= j_reg + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            wcnt  <= '0;
            state <= ST_WMUL;
          end
        end
        ST_WMUL: begin
          if (wcnt == 3'd4) begin
            state <= ST_EMIT;
          end else begin
            wcnt <= wcnt + 3'd1;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            if (last_i) begin
              state <= ST_COLLECT;
            end else begin
              i_reg <= i_reg + IW'(1);
              state <= ST_SETUP;
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  // weighting starts only once every product has reached the accumulators
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WMUL) |-> pipe_empty)
    else $error("weighting started with products in flight");

  // a sample either closes the block or advances the fill count
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_SETUP) || (fill != '0))
    else $error("sample neither closed the block nor advanced the fill");

  // the last flag follows the final result index of the block
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (last == $past(last_i)) && out_valid)
    else $error("result register loaded with wrong last flag");

endmodule

`default_nettype wire
